FILE: hdl/rcmix_pkg.sv
package rcmix_pkg;

  localparam int PULSE_BITS = 12;
  localparam int COUNT_BITS = 4;
  localparam int IVL_W = 16;
  localparam int CFG_W = 12;
  localparam int HYST_W = 4;
  localparam int CMD_W = 8;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 3;
  localparam int CMP_W = (COUNT_BITS > HYST_W) ? COUNT_BITS : HYST_W;
  localparam int BAND_W = (PULSE_BITS > CFG_W) ? PULSE_BITS : CFG_W;

  localparam logic [REG_IDX_W-1:0] REG_PULSE_LIMIT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENGAGE_THRESHOLD = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HYSTERESIS_COUNT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STEER_BAND_LOW = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STEER_BAND_HIGH = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_THROTTLE_BAND_LOW = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_THROTTLE_BAND_HIGH = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_AUTO_THROTTLE_MAX = 3'd7;

  localparam logic [CFG_W-1:0] RST_PULSE_LIMIT = 12'd2000;
  localparam logic [CFG_W-1:0] RST_ENGAGE_THRESHOLD = 12'd1700;
  localparam logic [HYST_W-1:0] RST_HYSTERESIS_COUNT = 4'd3;
  localparam logic [CFG_W-1:0] RST_STEER_BAND_LOW = 12'd1353;
  localparam logic [CFG_W-1:0] RST_STEER_BAND_HIGH = 12'd1647;
  localparam logic [CFG_W-1:0] RST_THROTTLE_BAND_LOW = 12'd1388;
  localparam logic [CFG_W-1:0] RST_THROTTLE_BAND_HIGH = 12'd1582;
  localparam logic [CMD_W-1:0] RST_AUTO_THROTTLE_MAX = 8'd115;

  localparam logic [CMD_W-1:0] STEER_IDLE = 8'd98;
  localparam logic [CMD_W-1:0] STEER_MAX = 8'd123;
  localparam logic [CMD_W-1:0] STEER_MIN = 8'd68;
  localparam logic [CMD_W-1:0] THR_IDLE = 8'd90;
  localparam logic [CMD_W-1:0] THR_MAN_MAX = 8'd102;
  localparam logic [CMD_W-1:0] THR_MIN = 8'd70;

  localparam logic [PULSE_BITS-1:0] ST_IDLE_LO = PULSE_BITS'(1470);
  localparam logic [PULSE_BITS-1:0] ST_IDLE_HI = PULSE_BITS'(1530);
  localparam logic [PULSE_BITS-1:0] TH_IDLE_LO = PULSE_BITS'(1455);
  localparam logic [PULSE_BITS-1:0] TH_IDLE_HI = PULSE_BITS'(1515);

  // Distances past which each branch of the mapping hits its clamp.
  localparam logic [PULSE_BITS-1:0] ST_HI_SPAN = PULSE_BITS'(350);
  localparam logic [PULSE_BITS-1:0] ST_LO_SPAN = PULSE_BITS'(290);
  localparam logic [PULSE_BITS-1:0] TH_HI_SPAN = PULSE_BITS'(201);
  localparam logic [PULSE_BITS-1:0] TH_LO_SPAN = PULSE_BITS'(363);

  // Reciprocals for exact division by 14, 29, 67 and 363 over the used ranges.
  localparam logic [12:0] RCP_14 = 13'd4682;
  localparam logic [10:0] RCP_29 = 11'd1130;
  localparam logic [9:0] RCP_67 = 10'd979;
  localparam logic [11:0] RCP_363 = 12'd2889;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [CFG_W-1:0] pulse_limit;
    logic [CFG_W-1:0] engage_threshold;
    logic [HYST_W-1:0] hysteresis_count;
    logic [CFG_W-1:0] steer_band_low;
    logic [CFG_W-1:0] steer_band_high;
    logic [CFG_W-1:0] throttle_band_low;
    logic [CFG_W-1:0] throttle_band_high;
    logic [CMD_W-1:0] auto_throttle_max;
  } cfg_t;

  typedef struct packed {
    logic [IVL_W-1:0] steer_interval;
    logic steer_new;
    logic [IVL_W-1:0] throttle_interval;
    logic throttle_new;
    logic [IVL_W-1:0] engage_interval;
    logic engage_new;
    logic [CMD_W-1:0] auto_steering_cmd;
    logic [CMD_W-1:0] auto_throttle_cmd;
  } item_t;

  typedef struct packed {
    logic [CMD_W-1:0] steering_out;
    logic [CMD_W-1:0] throttle_out;
    logic [CMD_W-1:0] manual_steering;
    logic [CMD_W-1:0] manual_throttle;
    logic engaged;
    logic steer_override;
    logic throttle_override;
  } res_t;

  typedef struct packed {
    logic [PULSE_BITS-1:0] held_steer_pulse;
    logic [PULSE_BITS-1:0] held_throttle_pulse;
    logic [COUNT_BITS-1:0] engage_count;
    logic [COUNT_BITS-1:0] disengage_count;
    logic engaged_flag;
    logic [COUNT_BITS-1:0] steer_override_count;
    logic [COUNT_BITS-1:0] throttle_override_count;
    logic steer_override_flag;
    logic throttle_override_flag;
  } state_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
  endfunction

  function automatic logic cnt_ge(input logic [COUNT_BITS-1:0] c,
                                  input logic [HYST_W-1:0] h);
    cnt_ge = CMP_W'(c) >= CMP_W'(h);
  endfunction

  function automatic logic out_of_band(input logic [PULSE_BITS-1:0] p,
                                       input logic [CFG_W-1:0] lo,
                                       input logic [CFG_W-1:0] hi);
    out_of_band = (BAND_W'(p) < BAND_W'(lo)) || (BAND_W'(p) > BAND_W'(hi));
  endfunction

  function automatic logic [CMD_W-1:0] clamp_hi_first(input logic [CMD_W-1:0] v,
                                                      input logic [CMD_W-1:0] lo,
                                                      input logic [CMD_W-1:0] hi);
    if (v > hi) begin
      clamp_hi_first = hi;
    end else if (v < lo) begin
      clamp_hi_first = lo;
    end else begin
      clamp_hi_first = v;
    end
  endfunction

endpackage

FILE: hdl/rcmix_cfg.sv
module rcmix_cfg
  import rcmix_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic [REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx = paddr[ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pulse_limit <= RST_PULSE_LIMIT;
      cfg_r.engage_threshold <= RST_ENGAGE_THRESHOLD;
      cfg_r.hysteresis_count <= RST_HYSTERESIS_COUNT;
      cfg_r.steer_band_low <= RST_STEER_BAND_LOW;
      cfg_r.steer_band_high <= RST_STEER_BAND_HIGH;
      cfg_r.throttle_band_low <= RST_THROTTLE_BAND_LOW;
      cfg_r.throttle_band_high <= RST_THROTTLE_BAND_HIGH;
      cfg_r.auto_throttle_max <= RST_AUTO_THROTTLE_MAX;
    end else if (wr_en) begin
      unique case (idx)
        REG_PULSE_LIMIT: cfg_r.pulse_limit <= pwdata[CFG_W-1:0];
        REG_ENGAGE_THRESHOLD: cfg_r.engage_threshold <= pwdata[CFG_W-1:0];
        REG_HYSTERESIS_COUNT: cfg_r.hysteresis_count <= pwdata[HYST_W-1:0];
        REG_STEER_BAND_LOW: cfg_r.steer_band_low <= pwdata[CFG_W-1:0];
        REG_STEER_BAND_HIGH: cfg_r.steer_band_high <= pwdata[CFG_W-1:0];
        REG_THROTTLE_BAND_LOW: cfg_r.throttle_band_low <= pwdata[CFG_W-1:0];
        REG_THROTTLE_BAND_HIGH: cfg_r.throttle_band_high <= pwdata[CFG_W-1:0];
        REG_AUTO_THROTTLE_MAX: cfg_r.auto_throttle_max <= pwdata[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PULSE_LIMIT: prdata = DATA_W'(cfg_r.pulse_limit);
      REG_ENGAGE_THRESHOLD: prdata = DATA_W'(cfg_r.engage_threshold);
      REG_HYSTERESIS_COUNT: prdata = DATA_W'(cfg_r.hysteresis_count);
      REG_STEER_BAND_LOW: prdata = DATA_W'(cfg_r.steer_band_low);
      REG_STEER_BAND_HIGH: prdata = DATA_W'(cfg_r.steer_band_high);
      REG_THROTTLE_BAND_LOW: prdata = DATA_W'(cfg_r.throttle_band_low);
      REG_THROTTLE_BAND_HIGH: prdata = DATA_W'(cfg_r.throttle_band_high);
      REG_AUTO_THROTTLE_MAX: prdata = DATA_W'(cfg_r.auto_throttle_max);
      default: prdata = '0;
    endcase
  end

endmodule

FILE: hdl/rcmix_map.sv
module rcmix_map
  import rcmix_pkg::*;
(
  input  logic [PULSE_BITS-1:0] steer_pulse,
  input  logic [PULSE_BITS-1:0] throttle_pulse,
  output logic [CMD_W-1:0]      manual_steering,
  output logic [CMD_W-1:0]      manual_throttle
);

  logic [PULSE_BITS-1:0] st_up_d, st_dn_d, th_up_d, th_dn_d;
  logic [21:0] st_up_prod;
  logic [9:0]  st_dn_x;
  logic [20:0] st_dn_prod;
  logic [9:0]  th_up_x;
  logic [19:0] th_up_prod;
  logic [12:0] th_dn_x;
  logic [24:0] th_dn_prod;

  assign st_up_d = steer_pulse - ST_IDLE_HI;
  assign st_dn_d = ST_IDLE_LO - steer_pulse;
  assign th_up_d = throttle_pulse - TH_IDLE_HI;
  assign th_dn_d = TH_IDLE_LO - throttle_pulse;

  // Above the idle band: 98 + d/14 and 90 + 4d/67.
  assign st_up_prod = st_up_d[8:0] * RCP_14;
  assign th_up_x = {st_up_d[0] & 1'b0, th_up_d[7:0], 1'b0} << 1;
  assign th_up_prod = th_up_x * RCP_67;

  // Below the idle band: 98 - ceil(3d/29) and 90 - ceil(20d/363).
  assign st_dn_x = 10'(st_dn_d[8:0] * 2'd3) + 10'd28;
  assign st_dn_prod = st_dn_x * RCP_29;
  assign th_dn_x = 13'(th_dn_d[8:0] * 5'd20) + 13'd362;
  assign th_dn_prod = th_dn_x * RCP_363;

  always_comb begin
    if (steer_pulse > ST_IDLE_LO && steer_pulse < ST_IDLE_HI) begin
      manual_steering = STEER_IDLE;
    end else if (steer_pulse >= ST_IDLE_HI) begin
      if (st_up_d >= ST_HI_SPAN) begin
        manual_steering = STEER_MAX;
      end else begin
        manual_steering = STEER_IDLE + CMD_W'(st_up_prod[20:16]);
      end
    end else if (st_dn_d >= ST_LO_SPAN) begin
      manual_steering = STEER_MIN;
    end else begin
      manual_steering = STEER_IDLE - CMD_W'(st_dn_prod[19:15]);
    end
  end

  always_comb begin
    if (throttle_pulse > TH_IDLE_LO && throttle_pulse < TH_IDLE_HI) begin
      manual_throttle = THR_IDLE;
    end else if (throttle_pulse >= TH_IDLE_HI) begin
      if (th_up_d >= TH_HI_SPAN) begin
        manual_throttle = THR_MAN_MAX;
      end else begin
        manual_throttle = THR_IDLE + CMD_W'(th_up_prod[19:16]);
      end
    end else if (th_dn_d >= TH_LO_SPAN) begin
      manual_throttle = THR_MIN;
    end else begin
      manual_throttle = THR_IDLE - CMD_W'(th_dn_prod[24:20]);
    end
  end

endmodule

FILE: hdl/rcmix_step.sv
module rcmix_step
  import rcmix_pkg::*;
(
  input  cfg_t   cfg,
  input  state_t st,
  input  item_t  item,
  output state_t st_nxt,
  output res_t   res
);

  logic st_take, th_take, en_take;
  logic [PULSE_BITS-1:0] held_s, held_t;
  logic [CMD_W-1:0] man_s, man_t, as_c, at_c, fs, ft, tmax;
  logic st_oob, th_oob;

  assign st_take = item.steer_new && (item.steer_interval < IVL_W'(cfg.pulse_limit));
  assign th_take = item.throttle_new
                   && (item.throttle_interval < IVL_W'(cfg.pulse_limit));
  assign en_take = item.engage_new && (item.engage_interval < IVL_W'(cfg.pulse_limit));

  assign held_s = st_take ? item.steer_interval[PULSE_BITS-1:0] : st.held_steer_pulse;
  assign held_t = th_take ? item.throttle_interval[PULSE_BITS-1:0]
                          : st.held_throttle_pulse;

  rcmix_map u_map (
    .steer_pulse     (held_s),
    .throttle_pulse  (held_t),
    .manual_steering (man_s),
    .manual_throttle (man_t)
  );

  assign st_oob = out_of_band(held_s, cfg.steer_band_low, cfg.steer_band_high);
  assign th_oob = out_of_band(held_t, cfg.throttle_band_low, cfg.throttle_band_high);

  always_comb begin
    st_nxt = st;
    st_nxt.held_steer_pulse = held_s;
    st_nxt.held_throttle_pulse = held_t;
    if (en_take) begin
      if (item.engage_interval > IVL_W'(cfg.engage_threshold)) begin
        st_nxt.engage_count = sat_inc(st.engage_count);
        st_nxt.disengage_count = '0;
      end else begin
        st_nxt.engage_count = '0;
        st_nxt.disengage_count = sat_inc(st.disengage_count);
      end
      if (cnt_ge(st_nxt.disengage_count, cfg.hysteresis_count)) begin
        st_nxt.engaged_flag = 1'b0;
      end else if (cnt_ge(st_nxt.engage_count, cfg.hysteresis_count)) begin
        st_nxt.engaged_flag = 1'b1;
      end
    end
    if (st_oob) begin
      st_nxt.steer_override_count = sat_inc(st.steer_override_count);
      if (cnt_ge(st_nxt.steer_override_count, cfg.hysteresis_count)) begin
        st_nxt.steer_override_flag = 1'b1;
      end
    end else begin
      st_nxt.steer_override_count = '0;
      st_nxt.steer_override_flag = 1'b0;
    end
    if (th_oob) begin
      st_nxt.throttle_override_count = sat_inc(st.throttle_override_count);
      if (cnt_ge(st_nxt.throttle_override_count, cfg.hysteresis_count)) begin
        st_nxt.throttle_override_flag = 1'b1;
      end
    end else begin
      st_nxt.throttle_override_count = '0;
      st_nxt.throttle_override_flag = 1'b0;
    end
  end

  assign as_c = clamp_hi_first(item.auto_steering_cmd, STEER_MIN, STEER_MAX);
  assign at_c = clamp_hi_first(item.auto_throttle_cmd, THR_MIN, cfg.auto_throttle_max);

  always_comb begin
    priority if (!st_nxt.engaged_flag) begin
      fs = man_s;
      ft = man_t;
      tmax = THR_MAN_MAX;
    end else if (st_nxt.steer_override_flag) begin
      fs = man_s;
      ft = at_c;
      tmax = cfg.auto_throttle_max;
    end else if (st_nxt.throttle_override_flag) begin
      fs = as_c;
      ft = man_t;
      tmax = THR_MAN_MAX;
    end else begin
      fs = as_c;
      ft = at_c;
      tmax = cfg.auto_throttle_max;
    end
  end

  assign res.steering_out = clamp_hi_first(fs, STEER_MIN, STEER_MAX);
  assign res.throttle_out = clamp_hi_first(ft, THR_MIN, tmax);
  assign res.manual_steering = man_s;
  assign res.manual_throttle = man_t;
  assign res.engaged = st_nxt.engaged_flag;
  assign res.steer_override = st_nxt.steer_override_flag;
  assign res.throttle_override = st_nxt.throttle_override_flag;

endmodule

FILE: hdl/rc_manual_autonomous_mixer_core.sv
// A word accepted at a clock edge waits in the input register until the output
// side is not stalled; then its result word is registered and put on the output.
// Throughput: one word per cycle when the output is not stalled; the input and
// result registers hold one word each, and the state update sits between them.
// Reset (rst_n low at a clock edge) restores the default configuration, clears
// all counters, held pulses and flags, and empties both registers.
module rc_manual_autonomous_mixer_core
  import rcmix_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IVL_W-1:0]  in_steer_interval,
  input  logic              in_steer_new,
  input  logic [IVL_W-1:0]  in_throttle_interval,
  input  logic              in_throttle_new,
  input  logic [IVL_W-1:0]  in_engage_interval,
  input  logic              in_engage_new,
  input  logic [CMD_W-1:0]  in_auto_steering_cmd,
  input  logic [CMD_W-1:0]  in_auto_throttle_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CMD_W-1:0]  out_steering_out,
  output logic [CMD_W-1:0]  out_throttle_out,
  output logic [CMD_W-1:0]  out_manual_steering,
  output logic [CMD_W-1:0]  out_manual_throttle,
  output logic              out_engaged,
  output logic              out_steer_override,
  output logic              out_throttle_override,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t   cfg;
  item_t  item_r;
  logic   item_valid_r;
  state_t state_r, state_nxt;
  res_t   res_nxt, res_r;
  logic   out_valid_r;
  logic   advance;

  rcmix_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcmix_step u_step (
    .cfg    (cfg),
    .st     (state_r),
    .item   (item_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  assign advance = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.steer_interval <= in_steer_interval;
      item_r.steer_new <= in_steer_new;
      item_r.throttle_interval <= in_throttle_interval;
      item_r.throttle_new <= in_throttle_new;
      item_r.engage_interval <= in_engage_interval;
      item_r.engage_new <= in_engage_new;
      item_r.auto_steering_cmd <= in_auto_steering_cmd;
      item_r.auto_throttle_cmd <= in_auto_throttle_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_steering_out = res_r.steering_out;
  assign out_throttle_out = res_r.throttle_out;
  assign out_manual_steering = res_r.manual_steering;
  assign out_manual_throttle = res_r.manual_throttle;
  assign out_engaged = res_r.engaged;
  assign out_steer_override = res_r.steer_override;
  assign out_throttle_override = res_r.throttle_override;

endmodule

FILE: sim/rc_manual_autonomous_mixer_core_tb.sv
`timescale 1ns / 100ps

module rc_manual_autonomous_mixer_core_tb;
  import rcmix_pkg::*;

  localparam int STEER_RX_TOP = 1880;
  localparam int STEER_RX_BOTTOM = 1180;
  localparam int THR_RX_TOP = 1716;
  localparam int THR_RX_BOTTOM = 1092;

  class mix_scoreboard;
    cfg_t regs;
    logic [PULSE_BITS-1:0] held_steer;
    logic [PULSE_BITS-1:0] held_throttle;
    logic [COUNT_BITS-1:0] engage_run;
    logic [COUNT_BITS-1:0] release_run;
    logic [COUNT_BITS-1:0] steer_run;
    logic [COUNT_BITS-1:0] throttle_run;
    bit engaged;
    bit steer_ovr;
    bit throttle_ovr;
    res_t awaited[$];
    int errors;

    function new();
      regs.pulse_limit = RST_PULSE_LIMIT;
      regs.engage_threshold = RST_ENGAGE_THRESHOLD;
      regs.hysteresis_count = RST_HYSTERESIS_COUNT;
      regs.steer_band_low = RST_STEER_BAND_LOW;
      regs.steer_band_high = RST_STEER_BAND_HIGH;
      regs.throttle_band_low = RST_THROTTLE_BAND_LOW;
      regs.throttle_band_high = RST_THROTTLE_BAND_HIGH;
      regs.auto_throttle_max = RST_AUTO_THROTTLE_MAX;
      held_steer = '0;
      held_throttle = '0;
      engage_run = '0;
      release_run = '0;
      steer_run = '0;
      throttle_run = '0;
      engaged = 1'b0;
      steer_ovr = 1'b0;
      throttle_ovr = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
      case (idx)
        REG_PULSE_LIMIT: regs.pulse_limit = v[CFG_W-1:0];
        REG_ENGAGE_THRESHOLD: regs.engage_threshold = v[CFG_W-1:0];
        REG_HYSTERESIS_COUNT: regs.hysteresis_count = v[HYST_W-1:0];
        REG_STEER_BAND_LOW: regs.steer_band_low = v[CFG_W-1:0];
        REG_STEER_BAND_HIGH: regs.steer_band_high = v[CFG_W-1:0];
        REG_THROTTLE_BAND_LOW: regs.throttle_band_low = v[CFG_W-1:0];
        REG_THROTTLE_BAND_HIGH: regs.throttle_band_high = v[CFG_W-1:0];
        REG_AUTO_THROTTLE_MAX: regs.auto_throttle_max = v[CMD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function int clamp_top_first(input int v, input int lo, input int hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // Piecewise receiver curve: flat inside the idle band, linear on each side,
    // with the quotient truncated and a negative result floored at zero.
    function int curve(input int p, input int idle, input int blo, input int bhi,
                       input int up_out, input int up_in, input int dn_out, input int dn_in);
      int n;
      if (p > blo && p < bhi) return idle;
      if (p >= bhi) return idle + (p - bhi) * up_out / up_in;
      n = idle * dn_in - (blo - p) * dn_out;
      return (n <= 0) ? 0 : n / dn_in;
    endfunction

    function bit track_override(input int p, input int lo, input int hi,
                                inout logic [COUNT_BITS-1:0] run, input bit flag);
      if (p < lo || p > hi) begin
        run = bump(run);
        if (int'(run) >= int'(regs.hysteresis_count)) flag = 1'b1;
      end else begin
        run = '0;
        flag = 1'b0;
      end
      return flag;
    endfunction

    function void note_input(input item_t w);
      int as_cmd, at_cmd, amax, man_s, man_t, fs, ft, tmax;
      res_t e;
      amax = regs.auto_throttle_max;
      if (w.steer_new && w.steer_interval < regs.pulse_limit)
        held_steer = w.steer_interval[PULSE_BITS-1:0];
      if (w.throttle_new && w.throttle_interval < regs.pulse_limit)
        held_throttle = w.throttle_interval[PULSE_BITS-1:0];
      if (w.engage_new && w.engage_interval < regs.pulse_limit) begin
        if (w.engage_interval > regs.engage_threshold) begin
          engage_run = bump(engage_run);
          release_run = '0;
        end else begin
          engage_run = '0;
          release_run = bump(release_run);
        end
        if (int'(release_run) >= int'(regs.hysteresis_count)) engaged = 1'b0;
        else if (int'(engage_run) >= int'(regs.hysteresis_count)) engaged = 1'b1;
      end
      as_cmd = clamp_top_first(w.auto_steering_cmd, STEER_MIN, STEER_MAX);
      at_cmd = clamp_top_first(w.auto_throttle_cmd, THR_MIN, amax);
      man_s = curve(held_steer, STEER_IDLE, ST_IDLE_LO, ST_IDLE_HI,
                    STEER_MAX - STEER_IDLE, STEER_RX_TOP - int'(ST_IDLE_HI),
                    STEER_IDLE - STEER_MIN, int'(ST_IDLE_LO) - STEER_RX_BOTTOM);
      man_t = curve(held_throttle, THR_IDLE, TH_IDLE_LO, TH_IDLE_HI,
                    THR_MAN_MAX - THR_IDLE, THR_RX_TOP - int'(TH_IDLE_HI),
                    THR_IDLE - THR_MIN, int'(TH_IDLE_LO) - THR_RX_BOTTOM);
      man_s = clamp_top_first(man_s, STEER_MIN, STEER_MAX);
      man_t = clamp_top_first(man_t, THR_MIN, THR_MAN_MAX);
      steer_ovr = track_override(held_steer, regs.steer_band_low, regs.steer_band_high,
                                 steer_run, steer_ovr);
      throttle_ovr = track_override(held_throttle, regs.throttle_band_low,
                                    regs.throttle_band_high, throttle_run, throttle_ovr);
      if (!engaged) begin
        fs = man_s;
        ft = man_t;
        tmax = THR_MAN_MAX;
      end else if (steer_ovr) begin
        fs = man_s;
        ft = at_cmd;
        tmax = amax;
      end else if (throttle_ovr) begin
        fs = as_cmd;
        ft = man_t;
        tmax = THR_MAN_MAX;
      end else begin
        fs = as_cmd;
        ft = at_cmd;
        tmax = amax;
      end
      fs = clamp_top_first(fs, STEER_MIN, STEER_MAX);
      ft = clamp_top_first(ft, THR_MIN, tmax);
      e.steering_out = 8'(fs);
      e.throttle_out = 8'(ft);
      e.manual_steering = 8'(man_s);
      e.manual_throttle = 8'(man_t);
      e.engaged = engaged;
      e.steer_override = steer_ovr;
      e.throttle_override = throttle_ovr;
      awaited.push_back(e);
    endfunction

    task report_mismatch(input string what, input int got, input int want);
      errors++;
      if (errors <= 100) $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task check_result(input res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result word with nothing pending, steering_out", got.steering_out, -1);
      end else begin
        want = awaited.pop_front();
        if (got.steering_out !== want.steering_out)
          report_mismatch("steering_out", got.steering_out, want.steering_out);
        if (got.throttle_out !== want.throttle_out)
          report_mismatch("throttle_out", got.throttle_out, want.throttle_out);
        if (got.manual_steering !== want.manual_steering)
          report_mismatch("manual_steering", got.manual_steering, want.manual_steering);
        if (got.manual_throttle !== want.manual_throttle)
          report_mismatch("manual_throttle", got.manual_throttle, want.manual_throttle);
        if (got.engaged !== want.engaged)
          report_mismatch("engaged", got.engaged, want.engaged);
        if (got.steer_override !== want.steer_override)
          report_mismatch("steer_override", got.steer_override, want.steer_override);
        if (got.throttle_override !== want.throttle_override)
          report_mismatch("throttle_override", got.throttle_override, want.throttle_override);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  item_t drv_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CMD_W-1:0] out_steering_out;
  logic [CMD_W-1:0] out_throttle_out;
  logic [CMD_W-1:0] out_manual_steering;
  logic [CMD_W-1:0] out_manual_throttle;
  logic out_engaged;
  logic out_steer_override;
  logic out_throttle_override;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mix_scoreboard sb = new();
  int burst_left = 0;
  logic [15:0] stall_pat = 16'hFFFF;
  int pat_age = 0;

  rc_manual_autonomous_mixer_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_steer_interval(drv_word.steer_interval),
    .in_steer_new(drv_word.steer_new),
    .in_throttle_interval(drv_word.throttle_interval),
    .in_throttle_new(drv_word.throttle_new),
    .in_engage_interval(drv_word.engage_interval),
    .in_engage_new(drv_word.engage_new),
    .in_auto_steering_cmd(drv_word.auto_steering_cmd),
    .in_auto_throttle_cmd(drv_word.auto_throttle_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_steering_out(out_steering_out),
    .out_throttle_out(out_throttle_out),
    .out_manual_steering(out_manual_steering),
    .out_manual_throttle(out_manual_throttle),
    .out_engaged(out_engaged),
    .out_steer_override(out_steer_override),
    .out_throttle_override(out_throttle_override),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(drv_word);
      if (out_valid && out_ready)
        sb.check_result('{out_steering_out, out_throttle_out, out_manual_steering,
                          out_manual_throttle, out_engaged, out_steer_override,
                          out_throttle_override});
    end
  end

  // The receiver rotates a stall pattern and swaps it for a new one now and then.
  always @(posedge clk) begin
    if (pat_age == 0) begin
      case ($urandom_range(3, 0))
        0: stall_pat <= 16'hFFFF;
        1: stall_pat <= 16'($urandom()) | 16'h0001;
        2: stall_pat <= ~(16'($urandom()) & 16'($urandom()));
        default: stall_pat <= (16'($urandom()) & 16'($urandom())) | 16'h0001;
      endcase
      pat_age <= $urandom_range(300, 40);
    end else begin
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
      pat_age <= pat_age - 1;
    end
    out_ready <= stall_pat[0];
  end

  initial begin
    #5000000;
    $display("rc_manual_autonomous_mixer_core_tb NOT OK");
    $finish;
  end

  function automatic item_t mk_word(input int si, input bit sn, input int ti, input bit tn,
                                    input int ei, input bit en, input int as_cmd,
                                    input int at_cmd);
    item_t w;
    w.steer_interval = 16'(si);
    w.steer_new = sn;
    w.throttle_interval = 16'(ti);
    w.throttle_new = tn;
    w.engage_interval = 16'(ei);
    w.engage_new = en;
    w.auto_steering_cmd = 8'(as_cmd);
    w.auto_throttle_cmd = 8'(at_cmd);
    return w;
  endfunction

  function automatic logic [15:0] gen_pulse(input int kind, input int lo, input int hi);
    int v;
    case (kind)
      0: v = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(4095, 0);
      1: begin
        if ($urandom_range(1, 0) == 0 && lo > 0)
          v = $urandom_range(lo - 1, (lo > 300) ? lo - 300 : 0);
        else if (hi < 4095)
          v = $urandom_range((hi < 3795) ? hi + 300 : 4095, hi + 1);
        else
          v = $urandom_range(4095, 0);
      end
      2: v = $urandom_range(2100, 900);
      3: v = int'(sb.regs.pulse_limit) + int'($urandom_range(1, 0)) - 1;
      default: v = $urandom();
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] gen_engage(input int kind);
    int thr, lim, v;
    thr = sb.regs.engage_threshold;
    lim = sb.regs.pulse_limit;
    case (kind)
      0: v = (thr + 1 <= lim - 1) ? $urandom_range((lim - 1 < thr + 400) ? lim - 1 : thr + 400,
                                                  thr + 1)
                                  : $urandom_range(4095, 0);
      1: v = $urandom_range(thr, (thr > 400) ? thr - 400 : 0);
      3: v = thr + int'($urandom_range(2, 0)) - 1;
      default: v = $urandom();
    endcase
    return v[15:0];
  endfunction

  task send_word(input item_t w);
    in_valid <= 1'b1;
    drv_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, DATA_W'(value));
    @(posedge clk);
  endtask

  task apply_setting(input int pl, input int et, input int hc, input int sbl, input int sbh,
                     input int tbl, input int tbh, input int atm);
    wait_for_results();
    repeat (4) @(posedge clk);
    write_reg(REG_PULSE_LIMIT, pl);
    write_reg(REG_ENGAGE_THRESHOLD, et);
    write_reg(REG_HYSTERESIS_COUNT, hc);
    write_reg(REG_STEER_BAND_LOW, sbl);
    write_reg(REG_STEER_BAND_HIGH, sbh);
    write_reg(REG_THROTTLE_BAND_LOW, tbl);
    write_reg(REG_THROTTLE_BAND_HIGH, tbh);
    write_reg(REG_AUTO_THROTTLE_MAX, atm);
  endtask

  function automatic int pick_kind(input int seg_kind);
    int r;
    r = $urandom_range(99, 0);
    if (r < 80) return seg_kind;
    if (r < 88) return 3;
    return 4;
  endfunction

  // Segments mostly hold both sticks, and in some the engage switch, in one regime
  // for a while, so that the hysteresis counters actually reach their thresholds.
  task random_words(input int n);
    int left, seg, st_kind, th_kind, en_kind;
    bit paused;
    item_t w;
    left = n;
    paused = 1'b0;
    while (left > 0) begin
      seg = $urandom_range(40, 4);
      st_kind = ($urandom_range(9, 0) < 4) ? 0 : ($urandom_range(2, 0) < 2) ? 1 : 2;
      th_kind = ($urandom_range(9, 0) < 4) ? 0 : ($urandom_range(2, 0) < 2) ? 1 : 2;
      en_kind = $urandom_range(4, 0);
      if ((!paused && left <= n / 2) || $urandom_range(14, 0) == 0) begin
        paused = 1'b1;
        wait_for_results();
      end
      while (seg > 0 && left > 0) begin
        w.steer_interval = gen_pulse(pick_kind(st_kind), sb.regs.steer_band_low,
                                     sb.regs.steer_band_high);
        w.throttle_interval = gen_pulse(pick_kind(th_kind), sb.regs.throttle_band_low,
                                        sb.regs.throttle_band_high);
        w.engage_interval = gen_engage((en_kind < 2) ? pick_kind(en_kind)
                                                     : $urandom_range(4, 0));
        w.steer_new = ($urandom_range(7, 0) != 0);
        w.throttle_new = ($urandom_range(7, 0) != 0);
        w.engage_new = ($urandom_range(7, 0) != 0);
        w.auto_steering_cmd = $urandom_range(255, 0);
        w.auto_throttle_cmd = $urandom_range(255, 0);
        send_word(w);
        pace();
        seg--;
        left--;
      end
    end
  endtask

  initial begin
    item_t directed[$];
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk_word(0, 1, 0, 1, 1800, 1, 0, 0));
    directed.push_back(mk_word(65535, 1, 65535, 1, 65535, 1, 255, 255));
    directed.push_back(mk_word(1999, 1, 1716, 1, 1800, 1, 123, 115));
    directed.push_back(mk_word(1470, 1, 1455, 1, 1800, 1, 68, 70));
    directed.push_back(mk_word(1471, 1, 1456, 1, 2000, 1, 67, 69));
    directed.push_back(mk_word(1529, 1, 1514, 1, 0, 0, 124, 116));
    directed.push_back(mk_word(1530, 1, 1515, 1, 0, 0, 255, 0));
    directed.push_back(mk_word(1880, 1, 1092, 1, 0, 0, 100, 100));
    directed.push_back(mk_word(1880, 0, 1092, 0, 0, 0, 100, 100));
    directed.push_back(mk_word(0, 0, 0, 0, 0, 0, 80, 90));
    directed.push_back(mk_word(1500, 1, 1716, 1, 1801, 1, 90, 110));
    directed.push_back(mk_word(1500, 1, 1500, 1, 1801, 1, 90, 110));
    directed.push_back(mk_word(1500, 1, 1500, 1, 1801, 1, 123, 115));
    directed.push_back(mk_word(1500, 1, 1500, 1, 1801, 1, 68, 70));
    directed.push_back(mk_word(1352, 1, 1583, 1, 1700, 1, 100, 100));
    directed.push_back(mk_word(1352, 1, 1583, 1, 1700, 1, 100, 100));
    directed.push_back(mk_word(1352, 1, 1583, 1, 1700, 1, 100, 100));
    directed.push_back(mk_word(1353, 1, 1582, 1, 1701, 1, 100, 100));
    directed.push_back(mk_word(1647, 1, 1388, 1, 1699, 1, 100, 100));
    directed.push_back(mk_word(1648, 1, 1387, 1, 1699, 1, 100, 100));
    directed.push_back(mk_word(1180, 1, 1091, 1, 0, 1, 0, 255));
    directed.push_back(mk_word(1179, 1, 1000, 1, 4095, 1, 255, 0));
    foreach (directed[i]) begin
      send_word(directed[i]);
      pace();
    end
    random_words(220);

    apply_setting(4095, 0, 1, 0, 4095, 0, 4095, 180);
    random_words(200);
    apply_setting(4095, 4095, 15, 4095, 0, 4095, 0, 0);
    random_words(200);
    apply_setting(2000, 1500, 0, 1353, 1647, 1388, 1582, 69);
    random_words(200);
    apply_setting(0, 1700, 2, 1353, 1647, 1388, 1582, 50);
    random_words(60);
    repeat (3) begin
      apply_setting($urandom_range(4095, 1500), $urandom_range(2000, 1200),
                    $urandom_range(6, 1), $urandom_range(1500, 1200),
                    $urandom_range(1800, 1450), $urandom_range(1500, 1200),
                    $urandom_range(1800, 1450), $urandom_range(180, 0));
      random_words(220);
    end
    apply_setting(RST_PULSE_LIMIT, RST_ENGAGE_THRESHOLD, RST_HYSTERESIS_COUNT,
                  RST_STEER_BAND_LOW, RST_STEER_BAND_HIGH, RST_THROTTLE_BAND_LOW,
                  RST_THROTTLE_BAND_HIGH, RST_AUTO_THROTTLE_MAX);
    random_words(200);

    wait_for_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rc_manual_autonomous_mixer_core_tb OK");
    end else begin
      $display("rc_manual_autonomous_mixer_core_tb NOT OK");
    end
    $finish;
  end

endmodule
